FILE: src/nra_pkg.sv
// Package for the nearest-neighbor resize address generator.
// Field widths, register indexes, reset values and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nra_pkg;

  localparam int unsigned InDimW   = 13;
  localparam int unsigned OutDimW  = 15;
  localparam int unsigned StepW    = 20;
  localparam int unsigned PlaneW   = 16;
  localparam int unsigned CountW   = 14;
  localparam int unsigned AccW     = 34;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam int unsigned DefMaxInDim     = 4096;
  localparam int unsigned DefStepFracBits = 16;
  localparam int unsigned OutDimMax       = 16384;

  localparam logic [InDimW-1:0]  RstInDim   = InDimW'(1);
  localparam logic [OutDimW-1:0] RstOutDim  = OutDimW'(1);
  localparam logic [StepW-1:0]   RstStep    = StepW'(65536);
  localparam logic [PlaneW-1:0]  RstPlanes  = PlaneW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgInWidth    = 3'd0,
    CfgInHeight   = 3'd1,
    CfgOutWidth   = 3'd2,
    CfgOutHeight  = 3'd3,
    CfgXStep      = 3'd4,
    CfgYStep      = 3'd5,
    CfgPlaneCount = 3'd6,
    CfgNone       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [AddrW-1:0] source_address;
    logic [AddrW-1:0] dest_address;
    logic             end_of_row;
    logic             end_of_plane;
    logic             end_of_job;
  } result_t;

endpackage

`default_nettype wire

FILE: src/nearest_resize_address_gen_core.sv
// Nearest-neighbor resize address generator: raster walk over a stack of
// output planes, source offsets from Q-format step accumulators.
// Depends on nra_pkg and nra_skid.
// Each result is registered, in the skid register if the output stalls.
// Throughput: 1 request per cycle while the skid slot is empty; all
//   address math for a pixel is one 13x13 multiply plus a 32-bit
//   three-input add between the state registers and the result register.
// Reset: async active-low; walk counters, accumulators and bases go to 0,
//   config registers to sizes 1, steps 1.0, one plane; output stage empty.
`timescale 1ns / 1ps
`default_nettype none

module nearest_resize_address_gen_core #(
  parameter int unsigned MAX_IN_DIM     = nra_pkg::DefMaxInDim,
  parameter int unsigned STEP_FRAC_BITS = nra_pkg::DefStepFracBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config write channel
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [nra_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nra_pkg::CfgDataW-1:0] cfg_data_i,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         restart_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [nra_pkg::AddrW-1:0]         source_address_o,
  output logic [nra_pkg::AddrW-1:0]         dest_address_o,
  output logic                              end_of_row_o,
  output logic                              end_of_plane_o,
  output logic                              end_of_job_o
);

  localparam int unsigned InDimW  = nra_pkg::InDimW;
  localparam int unsigned OutDimW = nra_pkg::OutDimW;
  localparam int unsigned CountW  = nra_pkg::CountW;
  localparam int unsigned PlaneW  = nra_pkg::PlaneW;
  localparam int unsigned AccW    = nra_pkg::AccW;
  localparam int unsigned AddrW   = nra_pkg::AddrW;
  localparam int unsigned StepW   = nra_pkg::StepW;
  // largest input size a 13-bit register can express after the cap
  localparam int unsigned InCap   = (MAX_IN_DIM < 8191) ? MAX_IN_DIM : 8191;

  // ---------------------------------------------------------------------
  // Config registers. Ready is constant; unknown indexes are dropped.
  // ---------------------------------------------------------------------
  logic [InDimW-1:0]  in_width_q, in_height_q;
  logic [OutDimW-1:0] out_width_q, out_height_q;
  logic [StepW-1:0]   x_step_q, y_step_q;
  logic [PlaneW-1:0]  plane_count_q;
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q    <= nra_pkg::RstInDim;
      in_height_q   <= nra_pkg::RstInDim;
      out_width_q   <= nra_pkg::RstOutDim;
      out_height_q  <= nra_pkg::RstOutDim;
      x_step_q      <= nra_pkg::RstStep;
      y_step_q      <= nra_pkg::RstStep;
      plane_count_q <= nra_pkg::RstPlanes;
    end else if (cfg_we) begin
      unique case (nra_pkg::cfg_reg_e'(cfg_index_i))
        nra_pkg::CfgInWidth:    in_width_q    <= cfg_data_i[InDimW-1:0];
        nra_pkg::CfgInHeight:   in_height_q   <= cfg_data_i[InDimW-1:0];
        nra_pkg::CfgOutWidth:   out_width_q   <= cfg_data_i[OutDimW-1:0];
        nra_pkg::CfgOutHeight:  out_height_q  <= cfg_data_i[OutDimW-1:0];
        nra_pkg::CfgXStep:      x_step_q      <= cfg_data_i[StepW-1:0];
        nra_pkg::CfgYStep:      y_step_q      <= cfg_data_i[StepW-1:0];
        nra_pkg::CfgPlaneCount: plane_count_q <= cfg_data_i[PlaneW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize saturates.
  logic [InDimW-1:0]  iw, ih;
  logic [OutDimW-1:0] ow, oh;
  logic [PlaneW-1:0]  pc;

  always_comb begin
    iw = in_width_q;
    if (in_width_q == '0) begin
      iw = InDimW'(1);
    end else if (32'(in_width_q) > MAX_IN_DIM) begin
      iw = InDimW'(InCap);
    end
    ih = in_height_q;
    if (in_height_q == '0) begin
      ih = InDimW'(1);
    end else if (32'(in_height_q) > MAX_IN_DIM) begin
      ih = InDimW'(InCap);
    end
    ow = out_width_q;
    if (out_width_q == '0) begin
      ow = OutDimW'(1);
    end else if (32'(out_width_q) > nra_pkg::OutDimMax) begin
      ow = OutDimW'(nra_pkg::OutDimMax);
    end
    oh = out_height_q;
    if (out_height_q == '0) begin
      oh = OutDimW'(1);
    end else if (32'(out_height_q) > nra_pkg::OutDimMax) begin
      oh = OutDimW'(nra_pkg::OutDimMax);
    end
    pc = (plane_count_q == '0) ? PlaneW'(1) : plane_count_q;
  end

  // ---------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------
  logic [CountW-1:0] out_col_q, out_col_d, cur_col;
  logic [CountW-1:0] out_row_q, out_row_d, cur_row;
  logic [PlaneW-1:0] plane_index_q, plane_index_d, cur_plane;
  logic [AccW-1:0]   col_acc_q, col_acc_d, cur_col_acc;
  logic [AccW-1:0]   row_acc_q, row_acc_d, cur_row_acc;
  logic [AddrW-1:0]  plane_base_q, plane_base_d, cur_plane_base;
  logic [AddrW-1:0]  dest_counter_q, dest_counter_d, cur_dest;

  logic              in_accept;
  nra_pkg::result_t  nxt_res;

  // restart clears the walk before this pixel is generated
  always_comb begin
    cur_col        = restart_i ? '0 : out_col_q;
    cur_row        = restart_i ? '0 : out_row_q;
    cur_plane      = restart_i ? '0 : plane_index_q;
    cur_col_acc    = restart_i ? '0 : col_acc_q;
    cur_row_acc    = restart_i ? '0 : row_acc_q;
    cur_plane_base = restart_i ? '0 : plane_base_q;
    cur_dest       = restart_i ? '0 : dest_counter_q;
  end

  // Source coordinates: integer part of the accumulators, clamped to edge.
  logic [AccW-1:0]          row_int, col_int;
  logic [InDimW-1:0]        ih_m1, iw_m1;
  logic [InDimW-1:0]        src_row, src_col;
  logic [2*InDimW-1:0]      row_base, plane_size;
  logic                     eor, eop, eoj;

  always_comb begin
    row_int    = cur_row_acc >> STEP_FRAC_BITS;
    col_int    = cur_col_acc >> STEP_FRAC_BITS;
    ih_m1      = ih - InDimW'(1);
    iw_m1      = iw - InDimW'(1);
    src_row    = (row_int > AccW'(ih_m1)) ? ih_m1 : row_int[InDimW-1:0];
    src_col    = (col_int > AccW'(iw_m1)) ? iw_m1 : col_int[InDimW-1:0];
    row_base   = (2*InDimW)'(src_row) * (2*InDimW)'(iw);
    plane_size = (2*InDimW)'(ih) * (2*InDimW)'(iw);

    eor = ({1'b0, cur_col} + OutDimW'(1)) >= ow;
    eop = eor && (({1'b0, cur_row} + OutDimW'(1)) >= oh);
    eoj = eop && (({1'b0, cur_plane} + (PlaneW+1)'(1)) >= {1'b0, pc});

    nxt_res.source_address = cur_plane_base + AddrW'(row_base) + AddrW'(src_col);
    nxt_res.dest_address   = cur_dest;
    nxt_res.end_of_row     = eor;
    nxt_res.end_of_plane   = eop;
    nxt_res.end_of_job     = eoj;
  end

  // Counter advance: column fastest, then row, then plane; wrap at job end.
  always_comb begin
    out_col_d      = cur_col + CountW'(1);
    col_acc_d      = cur_col_acc + AccW'(x_step_q);
    out_row_d      = cur_row;
    row_acc_d      = cur_row_acc;
    plane_index_d  = cur_plane;
    plane_base_d   = cur_plane_base;
    dest_counter_d = cur_dest + AddrW'(1);
    if (eor) begin
      out_col_d = '0;
      col_acc_d = '0;
      if (eop) begin
        out_row_d = '0;
        row_acc_d = '0;
        if (eoj) begin
          plane_index_d  = '0;
          plane_base_d   = '0;
          dest_counter_d = '0;
        end else begin
          plane_index_d = cur_plane + PlaneW'(1);
          plane_base_d  = cur_plane_base + AddrW'(plane_size);
        end
      end else begin
        out_row_d = cur_row + CountW'(1);
        row_acc_d = cur_row_acc + AccW'(y_step_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q      <= '0;
      out_row_q      <= '0;
      plane_index_q  <= '0;
      col_acc_q      <= '0;
      row_acc_q      <= '0;
      plane_base_q   <= '0;
      dest_counter_q <= '0;
    end else if (in_accept) begin
      out_col_q      <= out_col_d;
      out_row_q      <= out_row_d;
      plane_index_q  <= plane_index_d;
      col_acc_q      <= col_acc_d;
      row_acc_q      <= row_acc_d;
      plane_base_q   <= plane_base_d;
      dest_counter_q <= dest_counter_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register + skid; input stalls only when the skid slot is full
  // ---------------------------------------------------------------------
  nra_pkg::result_t out_res;

  assign in_accept = in_valid_i && !in_stall_o;

  nra_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (nxt_res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_stall_i (out_stall_i)
  );

  assign source_address_o = out_res.source_address;
  assign dest_address_o   = out_res.dest_address;
  assign end_of_row_o     = out_res.end_of_row;
  assign end_of_plane_o   = out_res.end_of_plane;
  assign end_of_job_o     = out_res.end_of_job;

`ifndef SYNTHESIS
  // a full skid slot means the result register is occupied
  a_stall_implies_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // last pixel of the job wraps every counter
  a_job_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && nxt_res.end_of_job) |=>
      (dest_counter_q == '0 && plane_index_q == '0 && plane_base_q == '0))
    else $error("counters did not wrap after end of job");

  // mid-row pixel advances the column by one
  a_col_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !nxt_res.end_of_row && !restart_i) |=>
      (out_col_q == CountW'($past(out_col_q) + CountW'(1))))
    else $error("column counter did not advance");
`endif

endmodule

`default_nettype wire

FILE: src/nra_skid.sv
// Two-entry output stage (result register plus skid register) for the
// resize address generator. Uses nra_pkg::result_t.
`timescale 1ns / 1ps
`default_nettype none

module nra_skid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire nra_pkg::result_t in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output nra_pkg::result_t      out_data_o,
  input  wire logic             out_stall_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  nra_pkg::result_t out_data_q, out_data_d;
  nra_pkg::result_t skid_data_q, skid_data_d;
  logic             push;
  logic             slot_free;

  assign push      = in_valid_i && !skid_valid_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_data_d  = in_data_i;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: test/nra_checker.sv
// Scoreboard for the nearest-neighbor resize address generator: tracks config
// writes and accepted requests, predicts each pixel's addresses and compares.
// Depends on nra_pkg.
`timescale 1ns / 1ps

module nra_checker
  import nra_pkg::*;
#(
  parameter int unsigned MAX_IN_DIM     = DefMaxInDim,
  parameter int unsigned STEP_FRAC_BITS = DefStepFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                restart_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [AddrW-1:0]    source_address_i,
  input  logic [AddrW-1:0]    dest_address_i,
  input  logic                end_of_row_i,
  input  logic                end_of_plane_i,
  input  logic                end_of_job_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // shadow config
  logic [InDimW-1:0]  in_width_q, in_height_q;
  logic [OutDimW-1:0] out_width_q, out_height_q;
  logic [StepW-1:0]   x_step_q, y_step_q;
  logic [PlaneW-1:0]  plane_count_q;

  // shadow walk state
  logic [CountW-1:0] col_q, row_q;
  logic [PlaneW-1:0] plane_q;
  logic [AccW-1:0]   col_acc_q, row_acc_q;
  logic [AddrW-1:0]  plane_base_q, dest_q;

  result_t pixel_addrs[$];
  result_t want_r, got_r;
  int      fails;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_walk();
    col_q        = '0;
    row_q        = '0;
    plane_q      = '0;
    col_acc_q    = '0;
    row_acc_q    = '0;
    plane_base_q = '0;
    dest_q       = '0;
  endtask

  task automatic check_field(input string field, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      fails++;
    end
  endtask

  // Addresses of the next output pixel, then advance the raster walk.
  task automatic walk_pixel(input logic restart, output result_t r);
    int unsigned       iw, ih, ow, oh, pc;
    logic [AccW-1:0]   src_row, src_col;
    logic [AddrW-1:0]  row_base;
    logic              eor, eop, eoj;
    iw = eff_dim(in_width_q, MAX_IN_DIM);
    ih = eff_dim(in_height_q, MAX_IN_DIM);
    ow = eff_dim(out_width_q, OutDimMax);
    oh = eff_dim(out_height_q, OutDimMax);
    pc = eff_dim(plane_count_q, 65535);
    if (restart) clear_walk();

    src_row = row_acc_q >> STEP_FRAC_BITS;
    if (src_row > ih - 1) src_row = ih - 1;
    src_col = col_acc_q >> STEP_FRAC_BITS;
    if (src_col > iw - 1) src_col = iw - 1;

    row_base = src_row[AddrW-1:0] * iw;
    eor = (col_q + 1) >= ow;
    eop = eor && ((row_q + 1) >= oh);
    eoj = eop && ((plane_q + 1) >= pc);

    r.source_address = plane_base_q + row_base + src_col[AddrW-1:0];
    r.dest_address   = dest_q;
    r.end_of_row     = eor;
    r.end_of_plane   = eop;
    r.end_of_job     = eoj;

    dest_q = dest_q + 1;
    if (eor) begin
      col_q     = '0;
      col_acc_q = '0;
      if (eop) begin
        row_q     = '0;
        row_acc_q = '0;
        if (eoj) begin
          plane_q      = '0;
          plane_base_q = '0;
          dest_q       = '0;
        end else begin
          plane_q      = plane_q + 1;
          plane_base_q = plane_base_q + iw * ih;
        end
      end else begin
        row_q     = row_q + 1;
        row_acc_q = row_acc_q + x_step_q * 0 + y_step_q;
      end
    end else begin
      col_q     = col_q + 1;
      col_acc_q = col_acc_q + x_step_q;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q    = RstInDim;
      in_height_q   = RstInDim;
      out_width_q   = RstOutDim;
      out_height_q  = RstOutDim;
      x_step_q      = RstStep;
      y_step_q      = RstStep;
      plane_count_q = RstPlanes;
      clear_walk();
      pixel_addrs.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first: anything leaving now was requested on an earlier edge
      if (out_valid_i && !out_stall_i) begin
        got_r = '{source_address_i, dest_address_i, end_of_row_i, end_of_plane_i,
                  end_of_job_i};
        if (pixel_addrs.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h/%0h", $time,
                   got_r.source_address, got_r.dest_address);
          fails++;
        end else begin
          want_r = pixel_addrs.pop_front();
          check_field("source_address", want_r.source_address, got_r.source_address);
          check_field("dest_address", want_r.dest_address, got_r.dest_address);
          check_field("end_of_row", want_r.end_of_row, got_r.end_of_row);
          check_field("end_of_plane", want_r.end_of_plane, got_r.end_of_plane);
          check_field("end_of_job", want_r.end_of_job, got_r.end_of_job);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgInWidth:    in_width_q    = cfg_data_i[InDimW-1:0];
          CfgInHeight:   in_height_q   = cfg_data_i[InDimW-1:0];
          CfgOutWidth:   out_width_q   = cfg_data_i[OutDimW-1:0];
          CfgOutHeight:  out_height_q  = cfg_data_i[OutDimW-1:0];
          CfgXStep:      x_step_q      = cfg_data_i[StepW-1:0];
          CfgYStep:      y_step_q      = cfg_data_i[StepW-1:0];
          CfgPlaneCount: plane_count_q = cfg_data_i[PlaneW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        walk_pixel(restart_i, want_r);
        pixel_addrs.push_back(want_r);
      end

      fail_count_o <= fails;
      pending_o    <= pixel_addrs.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Top of the resize address generator bench: clock, reset, request stimulus,
// config writes, receiver stalls and the verdict.
// Depends on nra_pkg, nearest_resize_address_gen_core and nra_checker.
`timescale 1ns / 1ps

module tb_top;
  import nra_pkg::*;

  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned IdleLimit  = 3000;  // cycles with no handshake at all

  // one config set plus how many requests to run under it
  typedef struct packed {
    logic [CfgDataW-1:0] in_w;
    logic [CfgDataW-1:0] in_h;
    logic [CfgDataW-1:0] out_w;
    logic [CfgDataW-1:0] out_h;
    logic [CfgDataW-1:0] x_step;
    logic [CfgDataW-1:0] y_step;
    logic [CfgDataW-1:0] planes;
    int unsigned         requests;
  } geom_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i = CfgNone;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AddrW-1:0]    source_address_o, dest_address_o;
  logic                end_of_row_o, end_of_plane_o, end_of_job_o;

  int          fail_count, pending;
  int unsigned snd_idle_pct = 35;
  int unsigned rcv_idle_pct = 52;
  logic        hold_off_req = 1'b0;
  int unsigned idle_cycles  = 0;

  nearest_resize_address_gen_core dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .restart_i,
    .out_valid_o,
    .out_stall_i,
    .source_address_o,
    .dest_address_o,
    .end_of_row_o,
    .end_of_plane_o,
    .end_of_job_o
  );

  nra_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .restart_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .source_address_i (source_address_o),
    .dest_address_i   (dest_address_o),
    .end_of_row_i     (end_of_row_o),
    .end_of_plane_i   (end_of_plane_o),
    .end_of_job_i     (end_of_job_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls; on a hold-off request it stalls without a break
  // while the sender keeps pushing, so the core backs up into its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog: a run that stops moving on every channel is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One pixel request. Random gaps go in front; returns on the accepting edge
  // with valid still high, so the next call can keep it up without a glitch.
  task automatic push_pixel(input logic restart);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop requesting and wait until every predicted pixel has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_geom(input geom_t g);
    write_reg(CfgInWidth, g.in_w);
    write_reg(CfgInHeight, g.in_h);
    write_reg(CfgOutWidth, g.out_w);
    write_reg(CfgOutHeight, g.out_h);
    write_reg(CfgXStep, g.x_step);
    write_reg(CfgYStep, g.y_step);
    write_reg(CfgPlaneCount, g.planes);
  endtask

  initial begin
    geom_t g;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config makes every pixel a one-pixel job.
    push_pixel(1'b0);
    push_pixel(1'b1);
    drain();

    // Unused register index must be harmless; then a 3x2 -> 5x3 upscale
    // over two planes with restarts mid-row and mid-plane.
    write_reg(CfgNone, CfgDataW'($urandom_range(20'hFFFFF)));
    apply_geom('{20'd3, 20'd2, 20'd5, 20'd3, 20'd39321, 20'd43690, 20'd2, 0});
    for (int i = 0; i < 20; i++) begin
      push_pixel(i == 7 || i == 16);
    end

    // Random phases. Walks are mostly left alone so rows, planes and jobs
    // complete; a few random restarts cut them short.
    for (int phase = 1; phase <= 12; phase++) begin
      drain();
      if (phase == 4) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 35;
      end else if (phase == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (phase)
        1:  g = '{20'd4, 20'd4, 20'd8, 20'd8, 20'd32768, 20'd32768, 20'd3, 25};
        2:  g = '{20'd8, 20'd6, 20'd4, 20'd3, 20'd131072, 20'd131072, 20'd2, 25};
        // zero sizes act as 1, zero steps pin the source to row/col 0
        3:  g = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 25};
        // oversized inputs clamp to 4096x4096; one pixel per plane, so the
        // plane base wraps past 2^32 after 256 planes
        4:  g = '{20'hFFFFF, 20'hFFFFF, 20'd1, 20'd1, 20'hFFFFF, 20'hFFFFF,
                  20'hFFFFF, 280};
        // max step runs past the last source column and row: clamped
        5:  g = '{20'd7, 20'd5, 20'd3, 20'd2, 20'hFFFFF, 20'hFFFFF, 20'd4, 25};
        // oversized output width clamps to 16384, row never ends here
        6:  g = '{20'd4096, 20'd1, 20'hFFFFF, 20'd1, 20'd1, 20'd65536, 20'd1, 25};
        7:  g = '{20'd5, 20'd3, 20'd10, 20'd6, 20'd32768, 20'd32768, 20'hFFFF, 25};
        8:  g = '{20'd1, 20'd1, 20'd3, 20'd2, 20'd65536, 20'd65536, 20'd1, 25};
        12: g = '{20'd1, 20'd1, 20'd1, 20'd1, 20'd65536, 20'd65536, 20'd1, 25};
        default: begin
          g.in_w     = $urandom_range(1, 12);
          g.in_h     = $urandom_range(1, 12);
          g.out_w    = $urandom_range(1, 12);
          g.out_h    = $urandom_range(1, 12);
          g.x_step   = (g.in_w << 16) / g.out_w;
          g.y_step   = (g.in_h << 16) / g.out_h;
          g.planes   = $urandom_range(1, 3);
          g.requests = 25;
        end
      endcase
      apply_geom(g);
      if (phase == 9) hold_off_req = 1'b1;
      for (int unsigned i = 0; i < g.requests; i++) begin
        push_pixel($urandom_range(99) < 2);
      end
      // size change mid-job: new sizes land while the walk is partway in
      if (phase == 10) begin
        drain();
        write_reg(CfgOutWidth, 20'd2);
        for (int i = 0; i < 6; i++) push_pixel(1'b0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/nra_pkg.sv
src/nra_skid.sv
src/nearest_resize_address_gen_core.sv
test/nra_checker.sv
test/tb_top.sv
